@@ design/xsbu_pkg.sv @@
// Package with shared types, constants and hash helpers of the sketch block.
`timescale 1ns / 1ps
package xsbu_pkg;

  localparam logic [63:0] MmC1 = 64'h87c37b91114253d5;
  localparam logic [63:0] MmC2 = 64'h4cf5ad432745937f;
  localparam logic [63:0] FmixM1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FmixM2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] KeyLen = 64'd8;
  localparam logic [31:0] CountMax = 32'hFFFFFFFF;

  localparam logic KindInsert = 1'b0;
  localparam logic KindRead   = 1'b1;

  localparam logic [0:0] RegBucketSeed = 1'b0;
  localparam logic [0:0] RegParitySeed = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_MEM,
    ST_OUT
  } xsbu_state_e;

  // Steps of one hash: k*=C1, rotate and k*=C2, the a/b mixing, then the
  // final mix of a and of b.
  typedef enum logic [4:0] {
    H_K1, H_K2, H_AB,
    H_A1, H_A2, H_A3, H_B1, H_B2, H_B3, H_FIN
  } hstep_e;

  function automatic logic [63:0] rotl31(input logic [63:0] v);
    rotl31 = {v[32:0], v[63:33]};
  endfunction

endpackage

@@ design/xor_sketch_bucket_update.sv @@
// Top level of the XOR cardinality sketch with bucket counters.
`timescale 1ns / 1ps
// The slave stream carries one request per item: kind in tuser, and in tdata
// the data value, the primary key and the read row. An insert hashes the data
// value under bucket_seed and then the primary key under parity_seed on one
// shared sequencer; it then increments the selected bucket counter
// (saturating) and XORs the parity bit into one sketch bit. A read returns
// one row's sketch bits and that row's counter.
// The state lives in two synchronous memories of ROWS entries each, with
// registered read data, and written back in the update step.
// One request is in flight at a time. A hash runs six 64-bit multiplies, each
// an issue step and three 32x32 partial products, and four further steps. The
// next request is taken once the result is loaded into the output register.
// The user must write seeds over the APB port only between requests; the block
// itself does not enforce it.
// Reset: after rst_ni rises, a clearing pass zeroes both memories, one entry
// a cycle; s_axis_tready stays low during it.
// When the receiver stalls, the result waits in the output register while one
// further request is taken and processed, then held in its update step.
module xor_sketch_bucket_update
  import xsbu_pkg::*;
#(
  parameter int ROWS  = 1024,
  parameter int WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: data_value[63:0], primary_key[127:64], read_row[137:128], zero pad
  input  logic [143:0] s_axis_tdata,
  // tuser: kind
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: touched_row[9:0], touched_column[14:10], flip_bit[15],
  // bucket_index[25:16], row_bits[57:26], bucket_count[89:58], zero pad
  output logic [95:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int NB = $clog2(ROWS) > 0 ? $clog2(ROWS) : 1;
  localparam int AW = NB;
  localparam int IB = (ROWS > 1) ? $clog2(ROWS + 1) - 1 : 1;
  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  // Config registers.
  logic [31:0] bucket_seed_q, parity_seed_q;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_seed_q <= '0;
      parity_seed_q <= '0;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegBucketSeed) bucket_seed_q <= pwdata;
      else                           parity_seed_q <= pwdata;
    end
  end
  always_comb begin
    case (paddr[2])
      RegBucketSeed: prdata = bucket_seed_q;
      default:       prdata = parity_seed_q;
    endcase
    if (paddr[1:0] != 2'b00) prdata = '0;
  end

  // Hash sequencer: a micro-program over one 64x64 low multiply,
  // built from three 32x32 partial products, one per cycle.
  xsbu_state_e state_q, state_d;
  hstep_e      hs_q;
  logic        hsel_q;          // 0 data value hash, 1 primary key hash
  logic [63:0] k_q, a_q, b_q, h0_q, h1_q;
  logic        kind_q;
  logic [63:0] pkey_q;
  logic [9:0]  rrow_q;

  // Multiplier unit.
  logic [63:0] mx_q, my_q, macc_q;
  logic [1:0]  mph_q;
  logic        mbusy_q, mstart, mdone;
  logic [63:0] mop_x, mop_y;
  logic [31:0] pa, pb;
  logic [63:0] pp;
  always_comb begin
    case (mph_q)
      2'd0:    begin pa = mx_q[31:0];  pb = my_q[31:0];  end
      2'd1:    begin pa = mx_q[63:32]; pb = my_q[31:0];  end
      default: begin pa = mx_q[31:0];  pb = my_q[63:32]; end
    endcase
    pp = 64'(pa) * 64'(pb);
  end
  assign mdone = mbusy_q && mph_q == 2'd2;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      mph_q   <= '0;
    end else if (mstart) begin
      mbusy_q <= 1'b1;
      mph_q   <= '0;
    end else if (mbusy_q) begin
      mph_q <= mph_q + 2'd1;
      if (mdone) mbusy_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (mstart) begin
      mx_q   <= mop_x;
      my_q   <= mop_y;
      macc_q <= '0;
    end else if (mbusy_q) begin
      if (mph_q == 2'd0) macc_q <= pp;
      else               macc_q <= macc_q + {pp[31:0], 32'd0};
    end
  end
  logic [63:0] mres;
  assign mres = macc_q + {pp[31:0], 32'd0};

  // Memories.
  logic [31:0] cnt_mem [ROWS];
  logic [WIDTH-1:0] bit_mem [ROWS];
  logic          wr_en;
  logic [31:0]   cnt_wdata, cnt_rdata_q;
  logic [WIDTH-1:0] bit_wdata, bit_rdata_q;
  logic [AW-1:0] cnt_waddr, bit_waddr, cnt_raddr, bit_raddr;
  always_ff @(posedge clk_i) begin
    cnt_rdata_q <= cnt_mem[cnt_raddr];
    bit_rdata_q <= bit_mem[bit_raddr];
    if (wr_en) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
      bit_mem[bit_waddr] <= bit_wdata;
    end
  end

  // Clearing pass.
  logic          clr_q;
  logic [AW:0]   clr_cnt_q;

  // Sequencer state.
  logic          hash_done;
  logic [63:0]   mix_in;
  logic [63:0]   ab_sum;

  assign ab_sum = a_q + b_q;

  // Operand selection for each hash step that multiplies.
  always_comb begin
    mop_x = k_q;
    mop_y = MmC1;
    unique case (hs_q)
      H_K1: begin mop_x = k_q; mop_y = MmC1; end
      H_K2: begin mop_x = rotl31(k_q); mop_y = MmC2; end
      H_A1, H_B1: begin mop_x = mix_in ^ (mix_in >> 33); mop_y = FmixM1; end
      H_A2, H_B2: begin mop_x = k_q ^ (k_q >> 33); mop_y = FmixM2; end
      default: begin mop_x = k_q; mop_y = MmC1; end
    endcase
  end
  assign mix_in = (hs_q == H_A1) ? a_q : b_q;

  logic started_q;
  assign mstart = state_q == ST_HASH && !mbusy_q && !started_q &&
                  hs_q != H_AB && hs_q != H_A3 && hs_q != H_B3 &&
                  hs_q != H_FIN;

  // Output register.
  logic        ovalid_q;
  logic        out_go;
  logic [95:0] odata_q;
  logic [NB-1:0] bidx_q, row_q;
  logic [CW-1:0] col_q;
  logic          flip_q;

  // The update step may run only when the output register is free or being
  // emptied in the same cycle.
  assign out_go = !ovalid_q || m_axis_tready;

  logic s_acc;
  assign s_axis_tready = state_q == ST_IDLE && !clr_q;
  assign s_acc = s_axis_tvalid & s_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_acc) state_d = (s_axis_tuser[0] == KindRead) ? ST_MEM : ST_HASH;
      ST_HASH: if (hash_done) state_d = ST_MEM;
      ST_MEM:  state_d = ST_OUT;
      ST_OUT:  if (out_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign hash_done = state_q == ST_HASH && hs_q == H_FIN && hsel_q;

  // Rank of h1.
  logic [CW-1:0] rank;
  always_comb begin
    rank = CW'(WIDTH - 1);
    for (int i = WIDTH - 2; i >= 0; i--) begin
      if (h1_q[i]) rank = CW'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      hs_q      <= H_K1;
      hsel_q    <= 1'b0;
      started_q <= 1'b0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + (AW+1)'(1);
        if (clr_cnt_q == (AW+1)'(ROWS - 1)) clr_q <= 1'b0;
      end
      if (mstart) started_q <= 1'b1;
      if (s_acc) begin
        hs_q   <= H_K1;
        hsel_q <= 1'b0;
      end else if (state_q == ST_HASH) begin
        if (mdone || hs_q == H_AB || hs_q == H_A3 || hs_q == H_B3) begin
          started_q <= 1'b0;
          hs_q <= hstep_e'(hs_q + 5'd1);
        end else if (hs_q == H_FIN) begin
          hs_q   <= H_K1;
          hsel_q <= 1'b1;
        end
      end
      if (state_q == ST_OUT && out_go) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  // Hash datapath.
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      kind_q <= s_axis_tuser[0];
      k_q    <= s_axis_tdata[63:0];
      pkey_q <= s_axis_tdata[127:64];
      rrow_q <= s_axis_tdata[137:128];
    end else if (state_q == ST_HASH) begin
      unique case (hs_q)
        H_K1: if (mdone) k_q <= mres;
        H_K2: if (mdone) begin
          a_q <= {32'd0, hsel_q ? parity_seed_q : bucket_seed_q} ^ mres ^ KeyLen;
          b_q <= {32'd0, hsel_q ? parity_seed_q : bucket_seed_q} ^ KeyLen;
        end
        H_AB: begin
          a_q <= a_q + b_q;
          b_q <= b_q + a_q + b_q;
        end
        H_A1, H_B1, H_A2, H_B2: if (mdone) k_q <= mres;
        H_A3: a_q <= k_q ^ (k_q >> 33);
        H_B3: b_q <= k_q ^ (k_q >> 33);
        H_FIN: begin
          if (!hsel_q) begin
            h0_q <= ab_sum;
            h1_q <= b_q + ab_sum;
            k_q  <= pkey_q;
          end else begin
            // The parity bit is the top bit of the key hash's first word.
            flip_q <= ab_sum[63];
          end
        end
        default: ;
      endcase
    end
  end

  // Address selection for the read-modify-write.
  logic rd_oor;
  always_comb begin
    cnt_raddr = AW'(rrow_q);
    bit_raddr = AW'(rrow_q);
    if (kind_q == KindInsert) begin
      cnt_raddr = AW'(h0_q[63 -: NB] >> (NB - IB));
      bit_raddr = AW'(h1_q[63 -: NB] >> (NB - IB));
    end
  end
  assign rd_oor = 32'(rrow_q) >= 32'(ROWS);

  logic [31:0]      cnt_new;
  logic [WIDTH-1:0] bit_new;
  assign cnt_new = (cnt_rdata_q == CountMax) ? cnt_rdata_q : cnt_rdata_q + 32'd1;
  assign bit_new = bit_rdata_q ^ (WIDTH'(flip_q) << col_q);

  always_comb begin
    wr_en     = clr_q || (state_q == ST_OUT && out_go && kind_q == KindInsert);
    cnt_waddr = clr_q ? clr_cnt_q[AW-1:0] : bidx_q;
    bit_waddr = clr_q ? clr_cnt_q[AW-1:0] : row_q;
    cnt_wdata = clr_q ? '0 : cnt_new;
    bit_wdata = clr_q ? '0 : bit_new;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MEM) begin
      bidx_q <= NB'(cnt_raddr);
      row_q  <= NB'(bit_raddr);
      col_q  <= (kind_q == KindInsert) ? rank : '0;
    end
    if (state_q == ST_OUT && out_go) begin
      if (kind_q == KindInsert) begin
        odata_q <= {6'd0, cnt_new, 32'(bit_new), 10'(bidx_q), flip_q,
                    5'(col_q), 10'(row_q)};
      end else begin
        odata_q <= {6'd0, rd_oor ? 32'd0 : cnt_rdata_q,
                    rd_oor ? 32'd0 : 32'(bit_rdata_q), rrow_q, 1'b0, 5'd0, rrow_q};
      end
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

endmodule

@@ design/xsbu_checker.sv @@
// Port-level checker of the sketch block, bound to the top level.
`timescale 1ns / 1ps
module xsbu_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic        pready
);
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_handshake_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({m_axis_tvalid, s_axis_tready}))
    else $error("handshake signal unknown");
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken in flight");
  a_pready: assert property (@(posedge clk_i) pready)
    else $error("pready low");
endmodule

bind xor_sketch_bucket_update xsbu_props u_xsbu_props (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .pready(pready)
);

@@ bench/xsbu_checker.sv @@
// Checker that predicts the sketch block's results and compares them.
`timescale 1ns / 1ps
module xsbu_checker
  import xsbu_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,
  input  logic [0:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [95:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fail_count_o,
  output int           pending_o
);

  // Members from the highest bits down, matching the result tdata layout.
  typedef struct packed {
    logic [31:0] count;
    logic [31:0] bits;
    logic [9:0]  bucket;
    logic        flip;
    logic [4:0]  column;
    logic [9:0]  row;
  } sketch_result_t;

  logic [31:0] sketch_mem [1024];
  logic [31:0] counter_mem [1024];
  logic [31:0] bucket_seed_q, parity_seed_q;
  sketch_result_t expected_q[$];

  function automatic logic [63:0] mix_final(input logic [63:0] k);
    k ^= k >> 33;
    k *= 64'hff51afd7ed558ccd;
    k ^= k >> 33;
    k *= 64'hc4ceb9fe1a85ec53;
    k ^= k >> 33;
    return k;
  endfunction

  // MurmurHash3 x64_128 over a single 8-byte key; returns {h1, h0}.
  function automatic logic [127:0] murmur_key8(input logic [63:0] key, input logic [31:0] seed);
    logic [63:0] a, b, k;
    a = {32'd0, seed};
    b = a;
    k = key * 64'h87c37b91114253d5;
    k = {k[32:0], k[63:33]};
    k = k * 64'h4cf5ad432745937f;
    a ^= k;
    a ^= 64'd8;
    b ^= 64'd8;
    a += b;
    b += a;
    a = mix_final(a);
    b = mix_final(b);
    a += b;
    b += a;
    return {b, a};
  endfunction

  function automatic sketch_result_t apply_row(input logic kind, input logic [143:0] data);
    sketch_result_t r;
    logic [127:0] hv, pv;
    r = '0;
    if (kind == KindRead) begin
      r.row = data[137:128];
      r.bucket = r.row;
      r.bits = sketch_mem[r.row];
      r.count = counter_mem[r.row];
    end else begin
      hv = murmur_key8(data[63:0], bucket_seed_q);
      pv = murmur_key8(data[127:64], parity_seed_q);
      r.bucket = hv[63:54];
      if (counter_mem[r.bucket] != CountMax) counter_mem[r.bucket]++;
      r.count = counter_mem[r.bucket];
      // Rank is the trailing-zero count of h1, capped at column 31.
      r.column = 5'd31;
      for (int i = 30; i >= 0; i--) if (hv[64+i]) r.column = i[4:0];
      r.row = hv[127:118];
      r.flip = pv[63];
      sketch_mem[r.row][r.column] ^= r.flip;
      r.bits = sketch_mem[r.row];
    end
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    sketch_result_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < 1024; i++) begin
        sketch_mem[i] = '0;
        counter_mem[i] = '0;
      end
      bucket_seed_q = '0;
      parity_seed_q = '0;
      fail_count_o = 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == 3'd0) bucket_seed_q = pwdata;
        else if (paddr == 3'd4) parity_seed_q = pwdata;
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(apply_row(s_axis_tuser[0], s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[89:0];
        if (expected_q.size() == 0) begin
          $error("unexpected result %h", got);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (got.row !== want.row) begin
            $error("touched_row exp %0d got %0d", want.row, got.row); fail_count_o++;
          end
          if (got.column !== want.column) begin
            $error("touched_column exp %0d got %0d", want.column, got.column); fail_count_o++;
          end
          if (got.flip !== want.flip) begin
            $error("flip_bit exp %0d got %0d", want.flip, got.flip); fail_count_o++;
          end
          if (got.bucket !== want.bucket) begin
            $error("bucket_index exp %0d got %0d", want.bucket, got.bucket); fail_count_o++;
          end
          if (got.bits !== want.bits) begin
            $error("row_bits exp %h got %h", want.bits, got.bits); fail_count_o++;
          end
          if (got.count !== want.count) begin
            $error("bucket_count exp %h got %h", want.count, got.count); fail_count_o++;
          end
        end
      end
    end
  end

endmodule

@@ bench/tb.sv @@
// Testbench top: drives rows, reads and seed writes into the sketch block.
`timescale 1ns / 1ps
module tb
  import xsbu_pkg::*;
;

  // The block holds one request at a time and clears 1024 entries after reset,
  // so a long idle stretch means it has hung.
  localparam int WatchdogLimit = 5000;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic [0:0]   s_axis_tuser;
  logic         m_axis_tvalid, m_axis_tready;
  logic [95:0]  m_axis_tdata;
  logic         psel, penable, pwrite, pready;
  logic [2:0]   paddr;
  logic [31:0]  pwdata, prdata;
  int           fail_count, pending;
  int           idle_cycles;
  bit           sink_hold;   // forces a long receiver stall
  bit           sink_free;   // receiver never stalls

  xor_sketch_bucket_update dut (.*);

  xsbu_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .psel, .penable, .pwrite,
    .paddr, .pwdata, .pready, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: counts cycles in which neither channel moves a request or a result.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stall per result, or a forced long hold-off.
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (sink_hold) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        sink_hold = 1'b0;
      end
      gap = sink_free ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Offers one request after a random gap, unless no_gap is set, and holds it until accepted.
  task automatic send_row(input logic kind, input logic [63:0] value,
                          input logic [63:0] key, input logic [9:0] row, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {6'd0, row, key, value};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_all();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random mix: mostly inserts, about a third of their values drawn from a small
  // pool so buckets and sketch bits fold over repeatedly, with reads of random rows.
  task automatic random_phase(input int count, input bit no_gap);
    logic [63:0] pool[16];
    logic [63:0] v;
    for (int i = 0; i < 16; i++) pool[i] = rand64();
    for (int i = 0; i < count; i++) begin
      v = ($urandom_range(0, 2) == 0) ? pool[$urandom_range(0, 15)] : rand64();
      if ($urandom_range(0, 4) == 0)
        send_row(KindRead, rand64(), rand64(), 10'($urandom_range(0, 1023)), no_gap);
      else
        send_row(KindInsert, v, rand64(), 10'($urandom_range(0, 1023)), no_gap);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    sink_hold = 1'b0; sink_free = 1'b0; idle_cycles = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset seeds, field extremes, reads of both ends of the store.
    send_row(KindRead, '0, '0, 10'd0, 1'b0);
    send_row(KindRead, '1, '1, 10'd1023, 1'b0);
    send_row(KindInsert, '0, '0, '0, 1'b0);
    send_row(KindInsert, '1, '1, '1, 1'b0);
    send_row(KindInsert, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 10'h155, 1'b0);
    send_row(KindInsert, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 10'h2AA, 1'b0);
    // The same insert four times XORs one parity bit into one sketch bit each time and bumps one counter four times.
    for (int i = 0; i < 4; i++) send_row(KindInsert, 64'h1234, 64'h9876, '0, 1'b0);
    for (int i = 0; i < 8; i++)
      send_row(KindRead, '0, '0, 10'($urandom_range(0, 1023)), 1'b0);
    drain_all();

    apb_write(3'd0, 32'hFFFF_FFFF);
    apb_write(3'd4, 32'hFFFF_FFFF);
    random_phase(400, 1'b0);

    // Sender pauses until every result has come back, then the receiver stalls
    // for a long stretch while the sender keeps offering back to back.
    drain_all();
    apb_write(3'd0, $urandom);
    apb_write(3'd4, $urandom);
    sink_hold = 1'b1;
    random_phase(300, 1'b1);
    drain_all();

    apb_write(3'd0, 32'd0);
    apb_write(3'd4, 32'h8000_0000);
    sink_free = 1'b1;
    random_phase(500, 1'b1);
    sink_free = 1'b0;
    drain_all();

    apb_write(3'd0, $urandom);
    apb_write(3'd4, 32'd0);
    random_phase(630, 1'b0);
    drain_all();

    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
